/* src/tft_rect_fill_command_stream_unit_defines.svh */
// Assertion macros used by the output buffer of the rectangle fill command stream unit
`ifndef TFT_RECT_FILL_COMMAND_STREAM_UNIT_DEFINES_SVH
`define TFT_RECT_FILL_COMMAND_STREAM_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TFTRF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define TFTRF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/tftrf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tftrf_pkg;

	// Request codes
	localparam logic [1:0] REQ_FILL = 2'd0;
	localparam logic [1:0] REQ_TICK = 2'd1;
	localparam logic [1:0] REQ_ROT  = 2'd2;
	localparam logic [1:0] REQ_INV  = 2'd3;

	// Register indexes
	localparam logic REG_SCREEN_W = 1'b0;
	localparam logic REG_SCREEN_H = 1'b1;

	// Controller command bytes
	localparam logic [7:0] CMD_CASET  = 8'h2A;
	localparam logic [7:0] CMD_RASET  = 8'h2B;
	localparam logic [7:0] CMD_RAMWR  = 8'h2C;
	localparam logic [7:0] CMD_MADCTL = 8'h36;
	localparam logic [7:0] CMD_INVOFF = 8'h20;
	localparam logic [7:0] CMD_INVON  = 8'h21;

	// Memory-control bits: row order, column order, row/column exchange
	localparam logic [7:0] MADCTL_MY   = 8'h80;
	localparam logic [7:0] MADCTL_MX   = 8'h40;
	localparam logic [7:0] MADCTL_MV   = 8'h20;
	localparam logic [7:0] MADCTL_NONE = 8'h00;

	// Header positions of a fill
	localparam logic [3:0] STEP_CASET  = 4'd0;
	localparam logic [3:0] STEP_XS_HI  = 4'd1;
	localparam logic [3:0] STEP_XS_LO  = 4'd2;
	localparam logic [3:0] STEP_XE_HI  = 4'd3;
	localparam logic [3:0] STEP_XE_LO  = 4'd4;
	localparam logic [3:0] STEP_RASET  = 4'd5;
	localparam logic [3:0] STEP_YS_HI  = 4'd6;
	localparam logic [3:0] STEP_YS_LO  = 4'd7;
	localparam logic [3:0] STEP_YE_HI  = 4'd8;
	localparam logic [3:0] STEP_YE_LO  = 4'd9;
	localparam logic [3:0] STEP_RAMWR  = 4'd10;
	localparam logic [3:0] STEP_PIXEL  = 4'd11;

	typedef enum logic [2:0] {
		JOB_FILL = 3'b001,
		JOB_ROT  = 3'b010,
		JOB_INV  = 3'b100
	} job_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] rect_x;
		logic [15:0] rect_y;
		logic [15:0] rect_w;
		logic [15:0] rect_h;
		logic [15:0] fill_rgb565;
		logic [1:0]  rotation_sel;
		logic        invert_on;
	} req_word_t;

	typedef struct packed {
		logic [7:0] bus_byte;
		logic       is_data;
		logic       end_of_transaction;
	} tx_word_t;

	// Mode byte per orientation
	function automatic logic [7:0] rot_mode(input logic [1:0] sel);
		logic [7:0] m;
		case (sel)
			2'd0:    m = MADCTL_MY | MADCTL_MX;
			2'd1:    m = MADCTL_MY | MADCTL_MV;
			2'd2:    m = MADCTL_NONE;
			default: m = MADCTL_MX | MADCTL_MV;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

/* src/tftrf_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module tftrf_seq import tftrf_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire req_word_t       req,
	input  wire logic            cfg_we,
	input  wire logic            cfg_index,
	input  wire logic [15:0]     cfg_wdata,
	output logic                 res_valid,
	output tx_word_t             res
);

	localparam int CB = COORD_BITS;

	logic [CB-1:0] screen_w_q, screen_h_q;

	logic          busy_q;
	job_t          job_q;
	logic [3:0]    step_q;
	logic          low_q;
	logic [CB-1:0] col_first_q, col_last_q, row_first_q, row_last_q;
	logic [CB-1:0] width_q, col_left_q, row_left_q;
	logic [15:0]   colour_q;
	logic [7:0]    setting_q;

	logic [CB-1:0] x, y, w, h;
	logic [CB:0]   x_end, y_end;
	logic          clip_x, clip_y, fill_ok;
	logic [CB-1:0] col_last_d, row_last_d, width_d, height_d;
	logic          is_tick, start, tick_busy, last_pixel;
	logic [15:0]   col_first16, col_last16, row_first16, row_last16;

	// Screen size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_w_q <= CB'(240);
			screen_h_q <= CB'(320);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_W: screen_w_q <= cfg_wdata[CB-1:0];
				REG_SCREEN_H: screen_h_q <= cfg_wdata[CB-1:0];
				default:      screen_w_q <= screen_w_q;
			endcase
		end
	end

	// Fill rejection and clipping
	assign x = req.rect_x[CB-1:0];
	assign y = req.rect_y[CB-1:0];
	assign w = req.rect_w[CB-1:0];
	assign h = req.rect_h[CB-1:0];
	assign x_end = {1'b0, x} + {1'b0, w} - (CB+1)'(1);
	assign y_end = {1'b0, y} + {1'b0, h} - (CB+1)'(1);
	assign clip_x = x_end >= {1'b0, screen_w_q};
	assign clip_y = y_end >= {1'b0, screen_h_q};
	assign fill_ok = (w != '0) && (h != '0) && (x < screen_w_q) && (y < screen_h_q);
	assign col_last_d = clip_x ? screen_w_q - CB'(1) : x_end[CB-1:0];
	assign row_last_d = clip_y ? screen_h_q - CB'(1) : y_end[CB-1:0];
	assign width_d  = clip_x ? screen_w_q - x : w;
	assign height_d = clip_y ? screen_h_q - y : h;

	assign is_tick   = req.req_type == REQ_TICK;
	assign start     = accept && !is_tick && !busy_q;
	assign tick_busy = accept && is_tick && busy_q;
	assign last_pixel = (col_left_q == CB'(1)) && (row_left_q == CB'(1));

	assign col_first16 = 16'(col_first_q);
	assign col_last16  = 16'(col_last_q);
	assign row_first16 = 16'(row_first_q);
	assign row_last16  = 16'(row_last_q);

	// Byte selection for a tick
	always_comb begin
		res_valid = tick_busy;
		res.bus_byte = 8'h00;
		res.is_data = 1'b1;
		res.end_of_transaction = 1'b0;
		case (job_q)
			JOB_FILL: begin
				case (step_q)
					STEP_CASET: begin res.bus_byte = CMD_CASET; res.is_data = 1'b0; end
					STEP_XS_HI: res.bus_byte = col_first16[15:8];
					STEP_XS_LO: res.bus_byte = col_first16[7:0];
					STEP_XE_HI: res.bus_byte = col_last16[15:8];
					STEP_XE_LO: res.bus_byte = col_last16[7:0];
					STEP_RASET: begin res.bus_byte = CMD_RASET; res.is_data = 1'b0; end
					STEP_YS_HI: res.bus_byte = row_first16[15:8];
					STEP_YS_LO: res.bus_byte = row_first16[7:0];
					STEP_YE_HI: res.bus_byte = row_last16[15:8];
					STEP_YE_LO: res.bus_byte = row_last16[7:0];
					STEP_RAMWR: begin res.bus_byte = CMD_RAMWR; res.is_data = 1'b0; end
					default: begin
						res.bus_byte = low_q ? colour_q[7:0] : colour_q[15:8];
						res.end_of_transaction = low_q && last_pixel;
					end
				endcase
			end
			JOB_ROT: begin
				if (step_q == STEP_CASET) begin
					res.bus_byte = CMD_MADCTL;
					res.is_data = 1'b0;
				end else begin
					res.bus_byte = setting_q;
					res.end_of_transaction = 1'b1;
				end
			end
			default: begin
				res.bus_byte = setting_q;
				res.is_data = 1'b0;
				res.end_of_transaction = 1'b1;
			end
		endcase
	end

	// Job control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			job_q  <= JOB_FILL;
			step_q <= STEP_CASET;
			low_q  <= 1'b0;
		end else if (start) begin
			case (req.req_type)
				REQ_FILL: begin
					if (fill_ok) begin
						busy_q <= 1'b1;
						job_q  <= JOB_FILL;
						step_q <= STEP_CASET;
						low_q  <= 1'b0;
					end
				end
				REQ_ROT: begin
					busy_q <= 1'b1;
					job_q  <= JOB_ROT;
					step_q <= STEP_CASET;
				end
				default: begin
					busy_q <= 1'b1;
					job_q  <= JOB_INV;
					step_q <= STEP_CASET;
				end
			endcase
		end else if (tick_busy) begin
			if (step_q < STEP_PIXEL)
				step_q <= step_q + 4'd1;
			if (job_q == JOB_FILL && step_q >= STEP_PIXEL)
				low_q <= !low_q;
			if (res.end_of_transaction)
				busy_q <= 1'b0;
		end
	end

	// Job payload and pixel counters
	always_ff @(posedge clk) begin
		if (start) begin
			if (req.req_type == REQ_FILL) begin
				col_first_q <= x;
				col_last_q  <= col_last_d;
				row_first_q <= y;
				row_last_q  <= row_last_d;
				width_q     <= width_d;
				col_left_q  <= width_d;
				row_left_q  <= height_d;
				colour_q    <= req.fill_rgb565;
			end else if (req.req_type == REQ_ROT) begin
				setting_q <= rot_mode(req.rotation_sel);
			end else begin
				setting_q <= req.invert_on ? CMD_INVON : CMD_INVOFF;
			end
		end else if (tick_busy && job_q == JOB_FILL && step_q >= STEP_PIXEL && low_q) begin
			// a pixel is done after its low byte
			if (col_left_q == CB'(1)) begin
				col_left_q <= width_q;
				row_left_q <= row_left_q - CB'(1);
			end else begin
				col_left_q <= col_left_q - CB'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* src/tftrf_obuf.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "tft_rect_fill_command_stream_unit_defines.svh"

module tftrf_obuf import tftrf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire tx_word_t push_word,
	output logic          full,
	output logic          tx_valid,
	input  wire logic     tx_stall,
	output tx_word_t      tx_word
);

	logic     main_valid_q, skid_valid_q;
	tx_word_t main_q, skid_q;
	logic     pop;

	assign pop      = main_valid_q && !tx_stall;
	assign full     = skid_valid_q;
	assign tx_valid = main_valid_q;
	assign tx_word  = main_q;

	// Output register with one skid word behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop)
				skid_valid_q <= 1'b0;
		end else if (push) begin
			if (main_valid_q && !pop)
				skid_valid_q <= 1'b1;
			else
				main_valid_q <= 1'b1;
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop)
				main_q <= skid_q;
		end else if (push) begin
			if (main_valid_q && !pop)
				skid_q <= push_word;
			else
				main_q <= push_word;
		end
	end

	`TFTRF_ASSERT_IMP(a_skid_behind_main, clk, arst_n, skid_valid_q, main_valid_q, "skid word without output word")
	`TFTRF_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !skid_valid_q, "word pushed into full buffer")
	`TFTRF_ASSERT_NXT(a_skid_drains, clk, arst_n, skid_valid_q && !tx_stall, main_valid_q && !skid_valid_q, "skid word not moved up")

endmodule

`default_nettype wire

/* src/tft_rect_fill_command_stream_unit.sv */
// Throughput: one request word per cycle while req_stall is low;
// one byte per cycle when tx is not stalled.
// req_stall rises only when the two-word output buffer is full.
// Reset: idle, output buffer empty, screen size 240 x 320 columns by rows.
`timescale 1ns / 1ps
`default_nettype none

module tft_rect_fill_command_stream_unit import tftrf_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire req_word_t   req_word,
	output logic             tx_valid,
	input  wire logic        tx_stall,
	output tx_word_t         tx_word,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	logic     accept;
	logic     res_valid;
	tx_word_t res;

	assign accept = req_valid && !req_stall;

	tftrf_seq #(
		.COORD_BITS(COORD_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req      (req_word),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.res_valid(res_valid),
		.res      (res)
	);

	tftrf_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_word(res),
		.full     (req_stall),
		.tx_valid (tx_valid),
		.tx_stall (tx_stall),
		.tx_word  (tx_word)
	);

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
	import tftrf_pkg::*;

	localparam int IDLE_LIMIT  = 2000;
	localparam int WORD_TARGET = 1250;
	localparam int PHASES      = 10;
	localparam int DIR_WORDS   = 25;
	// Rotation header position once the memory-control command has gone out
	localparam logic [3:0] ROT_MODE_NEXT = 4'd1;

	// One directed row: request word, and the byte typed in where it is obvious
	typedef struct packed {
		req_word_t w;
		logic      typed;
		logic      has;
		tx_word_t  e;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_word_t   req_word;
	logic        tx_valid;
	logic        tx_stall = 1'b0;
	tx_word_t    tx_word;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_wdata;

	tft_rect_fill_command_stream_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.tx_valid  (tx_valid),
		.tx_stall  (tx_stall),
		.tx_word   (tx_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Stream predictor state
	logic [15:0] scr_w, scr_h;
	logic        job_active;
	job_t        job_sel;
	logic [3:0]  hdr_pos;
	logic [31:0] px_remaining;
	logic        send_low;
	logic [15:0] win_x0, win_x1, win_y0, win_y1;
	logic [15:0] paint;
	logic [7:0]  mode_byte;

	tx_word_t    pending_bytes[$];
	stim_row_t   dir_rows[$];
	int          mismatches = 0;
	int          useful_words = 0;
	int          idle_cycles = 0;
	bit          quiet = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Advance the predicted stream by one accepted request word
	function automatic bit advance_stream(input req_word_t w, output tx_word_t b);
		int unsigned x, y, cw, rh;
		logic [3:0]  pos;
		b = '0;
		if (w.req_type != REQ_TICK) begin
			// anything but a tick is dropped while a job runs
			if (job_active)
				return 1'b0;
			case (w.req_type)
				REQ_FILL: begin
					x  = w.rect_x;
					y  = w.rect_y;
					cw = w.rect_w;
					rh = w.rect_h;
					if (cw == 0 || rh == 0 || x >= scr_w || y >= scr_h)
						return 1'b0;
					// clip to the screen edge
					if (x + cw - 1 >= scr_w)
						cw = scr_w - x;
					if (y + rh - 1 >= scr_h)
						rh = scr_h - y;
					win_x0       = 16'(x);
					win_x1       = 16'(x + cw - 1);
					win_y0       = 16'(y);
					win_y1       = 16'(y + rh - 1);
					px_remaining = cw * rh;
					paint        = w.fill_rgb565;
					send_low     = 1'b0;
					job_sel      = JOB_FILL;
				end
				REQ_ROT: begin
					case (w.rotation_sel)
						2'd0:    mode_byte = 8'hC0;
						2'd1:    mode_byte = 8'hA0;
						2'd2:    mode_byte = 8'h00;
						default: mode_byte = 8'h60;
					endcase
					job_sel = JOB_ROT;
				end
				default: begin
					mode_byte = w.invert_on ? CMD_INVON : CMD_INVOFF;
					job_sel   = JOB_INV;
				end
			endcase
			hdr_pos    = STEP_CASET;
			job_active = 1'b1;
			return 1'b0;
		end
		if (!job_active)
			return 1'b0;
		case (job_sel)
			JOB_FILL: begin
				pos = hdr_pos;
				if (pos < STEP_PIXEL)
					hdr_pos = pos + 4'd1;
				case (pos)
					STEP_CASET: b = {CMD_CASET, 2'b00};
					STEP_XS_HI: b = {win_x0[15:8], 2'b10};
					STEP_XS_LO: b = {win_x0[7:0], 2'b10};
					STEP_XE_HI: b = {win_x1[15:8], 2'b10};
					STEP_XE_LO: b = {win_x1[7:0], 2'b10};
					STEP_RASET: b = {CMD_RASET, 2'b00};
					STEP_YS_HI: b = {win_y0[15:8], 2'b10};
					STEP_YS_LO: b = {win_y0[7:0], 2'b10};
					STEP_YE_HI: b = {win_y1[15:8], 2'b10};
					STEP_YE_LO: b = {win_y1[7:0], 2'b10};
					STEP_RAMWR: b = {CMD_RAMWR, 2'b00};
					default: begin
						// pixel phase: high byte then low byte
						if (!send_low) begin
							send_low = 1'b1;
							b = {paint[15:8], 2'b10};
						end else begin
							send_low = 1'b0;
							if (px_remaining != 0)
								px_remaining = px_remaining - 1;
							b = {paint[7:0], 1'b1, px_remaining == 0};
						end
					end
				endcase
			end
			JOB_ROT: begin
				if (hdr_pos == STEP_CASET) begin
					hdr_pos = ROT_MODE_NEXT;
					b = {CMD_MADCTL, 2'b00};
				end else begin
					b = {mode_byte, 2'b11};
				end
			end
			default: b = {mode_byte, 2'b01};
		endcase
		if (b.end_of_transaction)
			job_active = 1'b0;
		return 1'b1;
	endfunction

	function automatic req_word_t rand_word(input logic [1:0] kind);
		req_word_t w;
		w.req_type     = kind;
		w.rect_x       = 16'($urandom_range(0, 65535));
		w.rect_y       = 16'($urandom_range(0, 65535));
		w.rect_w       = 16'($urandom_range(0, 65535));
		w.rect_h       = 16'($urandom_range(0, 65535));
		w.fill_rgb565  = 16'($urandom_range(0, 65535));
		w.rotation_sel = 2'($urandom_range(0, 3));
		w.invert_on    = 1'($urandom_range(0, 1));
		return w;
	endfunction

	// Origin and length along one axis of size s (s >= 1), kept to a small area
	function automatic logic [31:0] pick_span(input logic [15:0] s);
		logic [15:0] pos, len;
		int unsigned room;
		case ($urandom_range(0, 3))
			0, 1: begin
				pos = 16'($urandom_range(0, s - 1));
				len = 16'($urandom_range(1, 4));
			end
			2: begin
				// near the edge with any length, so it is mostly clipped
				room = (s < 5) ? s : 5;
				pos  = 16'(s - $urandom_range(1, room));
				len  = 16'($urandom_range(1, 65535));
			end
			default: begin
				pos = 16'($urandom_range(0, s - 1));
				len = (s <= 16) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 4));
			end
		endcase
		return {pos, len};
	endfunction

	function automatic stim_row_t stim(input int kind, input int x, input int y,
			input int cw, input int rh, input int rgb, input int rot, input int inv,
			input int typed, input int has, input tx_word_t e);
		stim_row_t r;
		r.w     = {2'(kind), 16'(x), 16'(y), 16'(cw), 16'(rh), 16'(rgb), 2'(rot), 1'(inv)};
		r.typed = 1'(typed);
		r.has   = 1'(has);
		r.e     = e;
		return r;
	endfunction

	// Send one request word and record the byte it should produce
	task automatic send_word(input req_word_t w, input logic typed, input logic typed_has,
			input tx_word_t typed_word);
		tx_word_t b;
		bit       has;
		while (!quiet && $urandom_range(0, 99) < 19) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_word  <= w;
		do
			@(posedge clk);
		while (req_stall);
		if ((w.req_type == REQ_TICK) == job_active)
			useful_words++;
		has = advance_stream(w, b);
		if (typed) begin
			has = typed_has;
			b   = typed_word;
		end
		if (has)
			pending_bytes.push_back(b);
	endtask

	// Tick until the running job has emitted its last byte
	task automatic finish_job();
		while (job_active)
			send_word(rand_word(REQ_TICK), 1'b0, 1'b0, '0);
	endtask

	// Let every expected byte drain, then wait on with no requests
	task automatic quiesce();
		req_valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_screen(input logic [15:0] sw, input logic [15:0] sh);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SCREEN_W;
		cfg_wdata <= sw;
		@(posedge clk);
		cfg_index <= REG_SCREEN_H;
		cfg_wdata <= sh;
		@(posedge clk);
		cfg_we <= 1'b0;
		scr_w = sw;
		scr_h = sh;
	endtask

	// Output checker and receiver stall
	always @(posedge clk) begin : tx_check
		tx_word_t want;
		if (arst_n && tx_valid && !tx_stall) begin
			if (pending_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: byte %h data %b last %b",
						tx_word.bus_byte, tx_word.is_data, tx_word.end_of_transaction);
			end else begin
				want = pending_bytes.pop_front();
				if (want.bus_byte !== tx_word.bus_byte || want.is_data !== tx_word.is_data
						|| want.end_of_transaction !== tx_word.end_of_transaction) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp byte %h data %b last %b, got byte %h data %b last %b",
							want.bus_byte, want.is_data, want.end_of_transaction,
							tx_word.bus_byte, tx_word.is_data, tx_word.end_of_transaction);
				end
			end
		end
		tx_stall <= !quiet && ($urandom_range(0, 99) < 19);
	end

	// Watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (tx_valid && !tx_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tft_rect_fill_command_stream_unit test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		req_word_t   w;
		int          k;
		logic [31:0] span;
		req_valid <= 1'b0;
		req_word  <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_SCREEN_W;
		cfg_wdata <= '0;
		arst_n    <= 1'b0;
		scr_w        = 16'd240;
		scr_h        = 16'd320;
		job_active   = 1'b0;
		job_sel      = JOB_FILL;
		hdr_pos      = STEP_CASET;
		px_remaining = '0;
		send_low     = 1'b0;
		win_x0       = '0;
		win_x1       = '0;
		win_y0       = '0;
		win_y1       = '0;
		paint        = '0;
		mode_byte    = '0;

		// Directed rows on the reset screen of 240 x 320
		dir_rows.push_back(stim(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 0, '0));
		dir_rows.push_back(stim(REQ_INV, 0, 0, 0, 0, 0, 0, 1, 1, 0, '0));
		dir_rows.push_back(stim(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 1, {CMD_INVON, 2'b01}));
		dir_rows.push_back(stim(REQ_INV, 0, 0, 0, 0, 0, 0, 0, 1, 0, '0));
		dir_rows.push_back(stim(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 1, {CMD_INVOFF, 2'b01}));
		dir_rows.push_back(stim(REQ_ROT, 0, 0, 0, 0, 0, 0, 0, 1, 0, '0));
		dir_rows.push_back(stim(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 1, {CMD_MADCTL, 2'b00}));
		// rotation request while busy is dropped
		dir_rows.push_back(stim(REQ_ROT, 0, 0, 0, 0, 0, 3, 0, 1, 0, '0));
		dir_rows.push_back(stim(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 1, {8'hC0, 2'b11}));
		dir_rows.push_back(stim(REQ_ROT, 0, 0, 0, 0, 0, 1, 0, 0, 0, '0));
		dir_rows.push_back(stim(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
		dir_rows.push_back(stim(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
		// empty and off-screen fills are rejected
		dir_rows.push_back(stim(REQ_FILL, 0, 0, 0, 5, 16'h1234, 0, 0, 1, 0, '0));
		dir_rows.push_back(stim(REQ_FILL, 0, 0, 5, 0, 16'h1234, 0, 0, 1, 0, '0));
		dir_rows.push_back(stim(REQ_FILL, 240, 0, 1, 1, 16'h1234, 0, 0, 1, 0, '0));
		dir_rows.push_back(stim(REQ_FILL, 0, 320, 1, 1, 16'h1234, 0, 0, 1, 0, '0));
		dir_rows.push_back(stim(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 0, '0));
		// bottom-right corner with maximal size clips to one pixel
		dir_rows.push_back(stim(REQ_FILL, 239, 319, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0,
			1, 0, '0));
		dir_rows.push_back(stim(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 1, {CMD_CASET, 2'b00}));
		dir_rows.push_back(stim(REQ_FILL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			3, 1, 0, 0, '0));
		dir_rows.push_back(stim(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
		dir_rows.push_back(stim(REQ_ROT, 0, 0, 0, 0, 0, 2, 0, 0, 0, '0));
		dir_rows.push_back(stim(REQ_INV, 0, 0, 0, 0, 0, 0, 1, 0, 0, '0));
		dir_rows.push_back(stim(REQ_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			3, 1, 0, 0, '0));
		dir_rows.push_back(stim(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].has, dir_rows[i].e);
		finish_job();

		// Random phases, each on its own screen size
		for (int p = 0; p < PHASES; p++) begin
			quiesce();
			case (p)
				0:       set_screen(16'd1, 16'd1);
				1:       set_screen(16'hFFFF, 16'hFFFF);
				2:       set_screen(16'd0, 16'd40);
				3:       set_screen(16'd240, 16'd320);
				4:       set_screen(16'd40, 16'd0);
				default: set_screen(16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)));
			endcase
			// one phase runs with no gaps on either side
			quiet = (p == 3);
			while (useful_words < DIR_WORDS + (p + 1) * (WORD_TARGET - DIR_WORDS) / PHASES)
					begin
				if (job_active) begin
					// mostly ticks, with some requests that must be dropped
					w = rand_word(REQ_TICK);
					if ($urandom_range(0, 9) == 0) begin
						case ($urandom_range(0, 2))
							0:       w.req_type = REQ_FILL;
							1:       w.req_type = REQ_ROT;
							default: w.req_type = REQ_INV;
						endcase
					end
				end else if ($urandom_range(0, 99) < 75) begin
					k = $urandom_range(0, 99);
					if (k < 70) begin
						w = rand_word(REQ_FILL);
						if (scr_w != 0 && scr_h != 0) begin
							span = pick_span(scr_w);
							w.rect_x = span[31:16];
							w.rect_w = span[15:0];
							span = pick_span(scr_h);
							w.rect_y = span[31:16];
							w.rect_h = span[15:0];
						end
					end else if (k < 85) begin
						w = rand_word(REQ_ROT);
					end else begin
						w = rand_word(REQ_INV);
					end
				end else begin
					// idle noise: stray tick or a fill that is rejected
					case ($urandom_range(0, 3))
						0: w = rand_word(REQ_TICK);
						1: begin
							w = rand_word(REQ_FILL);
							w.rect_w = '0;
						end
						2: begin
							w = rand_word(REQ_FILL);
							w.rect_h = '0;
						end
						default: begin
							w = rand_word(REQ_FILL);
							if ($urandom_range(0, 1))
								w.rect_x = 16'($urandom_range(scr_w, 65535));
							else
								w.rect_y = 16'($urandom_range(scr_h, 65535));
						end
					endcase
				end
				send_word(w, 1'b0, 1'b0, '0);
			end
			finish_job();
		end
		quiet = 1'b0;
		quiesce();

		if (mismatches == 0) begin
			$display("tft_rect_fill_command_stream_unit test passed");
		end else begin
			$display("tft_rect_fill_command_stream_unit test failed");
		end
		$finish;
	end

endmodule
